[src/spsu_pkg.sv]
// Shared types and constants for the sparse perceptron score and update block.
// Holds field widths, the default table size and the controller to datapath
// command and status words. No dependencies.
package spsu_pkg;

    localparam int FEATURE_COUNT_DEF = 4096;
    localparam int IDX_W             = 12;
    localparam int WORD_W            = 32;
    localparam int WIDE_W            = 48;
    localparam int FRAC_W            = 16;

    typedef struct packed {
        logic clear;
        logic load;
        logic mul1;
        logic acc;
        logic delta;
        logic mul2;
        logic write;
        logic emit;
    } spsu_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic op;
        logic last;
        logic out_free;
    } spsu_sts_t;

endpackage

[src/sparse_perceptron_score_update.sv]
// A score word passes the states MUL and ACC, and an update word the states MUL, DELTA,
// MUL2 and WRITE; after the last word of a run, EMIT registers the result word.
// The block takes no new word until it is back in IDLE, since the shared multiplier and
// the table read-modify-write serve one word at a time; EMIT waits while the output
// register is held by a stall.
// Reset: asynchronous, active low; then all min(FEATURE_COUNT, 4096) entries of both tables are cleared.
module sparse_perceptron_score_update #(
    parameter int FEATURE_COUNT = spsu_pkg::FEATURE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [spsu_pkg::IDX_W-1:0]            feature_index,
    input  logic signed [spsu_pkg::WORD_W-1:0]    feature_value,
    input  logic signed [spsu_pkg::WORD_W-1:0]    step_size,
    input  logic [spsu_pkg::WORD_W-1:0]           average_weight,
    input  logic                                  negate,
    input  logic                                  last_feature,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [spsu_pkg::WIDE_W-1:0]    score,
    output logic                                  saturated
);
    import spsu_pkg::*;

    spsu_cmd_t cmd;
    spsu_sts_t sts;

    spsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spsu_dp #(
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .feature_index  (feature_index),
        .feature_value  (feature_value),
        .step_size      (step_size),
        .average_weight (average_weight),
        .negate         (negate),
        .last_feature   (last_feature),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .score          (score),
        .saturated      (saturated)
    );

endmodule

[src/spsu_dp.sv]
// Datapath of the sparse perceptron block: weight and total tables, the
// shared multiplier, saturating adders, score accumulator and output word.
// Depends on spsu_pkg and is driven by commands from spsu_ctrl.
module spsu_dp #(
    parameter int FEATURE_COUNT = spsu_pkg::FEATURE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spsu_pkg::spsu_cmd_t                   cmd,
    output spsu_pkg::spsu_sts_t                   sts,
    input  logic                                  op,
    input  logic [spsu_pkg::IDX_W-1:0]            feature_index,
    input  logic signed [spsu_pkg::WORD_W-1:0]    feature_value,
    input  logic signed [spsu_pkg::WORD_W-1:0]    step_size,
    input  logic [spsu_pkg::WORD_W-1:0]           average_weight,
    input  logic                                  negate,
    input  logic                                  last_feature,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic signed [spsu_pkg::WIDE_W-1:0]    score,
    output logic                                  saturated
);
    import spsu_pkg::*;

    localparam int MEM_DEPTH = (FEATURE_COUNT < (1 << IDX_W)) ? FEATURE_COUNT : (1 << IDX_W);
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MUL_W     = WORD_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] L_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] L_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

    logic signed [WORD_W-1:0] w_mem [0:MEM_DEPTH-1];
    logic signed [WIDE_W-1:0] t_mem [0:MEM_DEPTH-1];

    logic                     op_reg;
    logic                     neg_reg;
    logic                     last_reg;
    logic                     idx_ok_reg;
    logic [AW-1:0]            addr_reg;
    logic signed [WORD_W-1:0] v_reg;
    logic signed [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0]        u_reg;
    logic signed [WORD_W-1:0] rd_w_reg;
    logic signed [WIDE_W-1:0] rd_t_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WORD_W-1:0] d_reg;
    logic signed [WORD_W-1:0] w_new_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] acc_next;
    logic                     sat_seen_reg;
    logic                     sat_seen_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [WIDE_W-1:0] score_reg;
    logic                     saturated_reg;
    logic [AW-1:0]            clr_cnt_reg;
    logic [AW-1:0]            clr_cnt_next;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [WIDE_W-1:0] sh48;

    logic                     d_ovf1;
    logic signed [WORD_W-1:0] d_sat1;
    logic signed [WORD_W:0]   d_neg;
    logic                     d_ovf2;
    logic signed [WORD_W-1:0] d_sat2;
    logic signed [WORD_W-1:0] d_delta;
    logic                     d_flag;

    logic signed [WORD_W:0]   w_sum;
    logic                     w_ovf;
    logic signed [WORD_W-1:0] w_new;

    logic signed [WIDE_W:0]   t_sum;
    logic                     t_ovf;
    logic signed [WIDE_W-1:0] t_new;

    logic signed [WIDE_W:0]   a_sum;
    logic                     a_ovf;
    logic signed [WIDE_W-1:0] a_new;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [WORD_W-1:0] mem_wd_w;
    logic signed [WIDE_W-1:0] mem_wd_t;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            neg_reg    <= negate;
            last_reg   <= last_feature;
            idx_ok_reg <= (32'(feature_index) < 32'(MEM_DEPTH));
            addr_reg   <= feature_index[AW-1:0];
            v_reg      <= feature_value;
            a_reg      <= step_size;
            u_reg      <= average_weight;
        end
    end

    always_comb
    begin
        mem_we    = cmd.clear | (cmd.write & idx_ok_reg);
        mem_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
        mem_wd_w  = cmd.clear ? '0 : w_new_reg;
        mem_wd_t  = cmd.clear ? '0 : t_new;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            w_mem[mem_waddr] <= mem_wd_w;
            t_mem[mem_waddr] <= mem_wd_t;
        end
        if (cmd.load)
        begin
            rd_w_reg <= w_mem[feature_index[AW-1:0]];
            rd_t_reg <= t_mem[feature_index[AW-1:0]];
        end
    end

    always_comb
    begin
        if (cmd.mul2)
        begin
            mul_a = {1'b0, u_reg};
            mul_b = {d_reg[WORD_W-1], d_reg};
        end
        else
        begin
            mul_b = {v_reg[WORD_W-1], v_reg};
            if (op_reg)
            begin
                mul_a = {a_reg[WORD_W-1], a_reg};
            end
            else if (idx_ok_reg)
            begin
                mul_a = {rd_w_reg[WORD_W-1], rd_w_reg};
            end
            else
            begin
                mul_a = '0;
            end
        end
    end

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1 || cmd.mul2)
        begin
            prod_reg <= prod_full;
        end
    end

    // An arithmetic shift of the product is the floor of the Q16.16 result.
    assign prod_sh = prod_reg >>> FRAC_W;
    assign sh48    = prod_sh[WIDE_W-1:0];

    always_comb
    begin
        d_ovf1  = (sh48[WIDE_W-1:WORD_W-1] != {(WIDE_W-WORD_W+1){sh48[WIDE_W-1]}});
        d_sat1  = d_ovf1 ? (sh48[WIDE_W-1] ? W_MIN : W_MAX) : sh48[WORD_W-1:0];
        d_neg   = -{d_sat1[WORD_W-1], d_sat1};
        d_ovf2  = (d_neg[WORD_W] != d_neg[WORD_W-1]);
        d_sat2  = d_ovf2 ? (d_neg[WORD_W] ? W_MIN : W_MAX) : d_neg[WORD_W-1:0];
        d_delta = neg_reg ? d_sat2 : d_sat1;
        d_flag  = d_ovf1 | (neg_reg & d_ovf2);

        w_sum = {rd_w_reg[WORD_W-1], rd_w_reg} + {d_reg[WORD_W-1], d_reg};
        w_ovf = (w_sum[WORD_W] != w_sum[WORD_W-1]);
        w_new = w_ovf ? (w_sum[WORD_W] ? W_MIN : W_MAX) : w_sum[WORD_W-1:0];

        t_sum = {rd_t_reg[WIDE_W-1], rd_t_reg} + {sh48[WIDE_W-1], sh48};
        t_ovf = (t_sum[WIDE_W] != t_sum[WIDE_W-1]);
        t_new = t_ovf ? (t_sum[WIDE_W] ? L_MIN : L_MAX) : t_sum[WIDE_W-1:0];

        a_sum = {acc_reg[WIDE_W-1], acc_reg} + {sh48[WIDE_W-1], sh48};
        a_ovf = (a_sum[WIDE_W] != a_sum[WIDE_W-1]);
        a_new = a_ovf ? (a_sum[WIDE_W] ? L_MIN : L_MAX) : a_sum[WIDE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.delta)
        begin
            d_reg <= d_delta;
        end
        if (cmd.mul2)
        begin
            w_new_reg <= w_new;
        end
        if (cmd.emit)
        begin
            score_reg     <= op_reg ? '0 : acc_reg;
            saturated_reg <= sat_seen_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc)
        begin
            acc_next = a_new;
        end
        if (cmd.emit)
        begin
            acc_next = '0;
        end

        sat_seen_next = sat_seen_reg
                      | (cmd.acc & a_ovf)
                      | (cmd.delta & d_flag)
                      | (cmd.mul2 & idx_ok_reg & w_ovf)
                      | (cmd.write & idx_ok_reg & t_ovf);
        if (cmd.emit)
        begin
            sat_seen_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end

        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sat_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            acc_reg       <= acc_next;
            sat_seen_reg  <= sat_seen_next;
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == AW'(MEM_DEPTH - 1));
    assign sts.op         = op_reg;
    assign sts.last       = last_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (acc_reg == '0) && !sat_seen_reg)
        else $error("Accumulator or flag not cleared after a result word.");

    a_update_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && op_reg |=> (score_reg == '0))
        else $error("Nonzero score on a run that ends with an update.");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("Result word lost after emit.");
`endif

endmodule

[src/spsu_ctrl.sv]
// Controller of the sparse perceptron block: sequences the table clear,
// the multiply and accumulate steps and the result word. Depends on
// spsu_pkg and drives the command word of spsu_dp.
module spsu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  spsu_pkg::spsu_sts_t sts,
    output spsu_pkg::spsu_cmd_t cmd
);
    import spsu_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_ACC   = 8'b0000_1000,
        ST_DELTA = 8'b0001_0000,
        ST_MUL2  = 8'b0010_0000,
        ST_WRITE = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } spsu_state_t;

    spsu_state_t state_reg;
    spsu_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = sts.op ? ST_DELTA : ST_ACC;
            end
            ST_ACC:
            begin
                state_next = sts.last ? ST_EMIT : ST_IDLE;
            end
            ST_DELTA:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = sts.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.clear = (state_reg == ST_CLEAR);
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.mul1  = (state_reg == ST_MUL);
        cmd.acc   = (state_reg == ST_ACC);
        cmd.delta = (state_reg == ST_DELTA);
        cmd.mul2  = (state_reg == ST_MUL2);
        cmd.write = (state_reg == ST_WRITE);
        cmd.emit  = (state_reg == ST_EMIT) && sts.out_free;
    end

    assign in_stall = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && !sts.out_free |=> (state_reg == ST_EMIT))
        else $error("Left the result state while the output word was full.");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_MUL))
        else $error("Accepted word did not start the multiply step.");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ACC) || (state_reg == ST_WRITE)) && sts.last
        |=> (state_reg == ST_EMIT))
        else $error("Last word of a run did not produce a result.");
`endif

endmodule

[tb/sparse_perceptron_score_update_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sparse_perceptron_score_update: random and directed feature
// words are predicted by a weight and running-total scoreboard and checked on every result.
// Depends on spsu_pkg and the block itself.

typedef struct {
    bit                     op;
    bit [11:0]              idx;
    bit signed [31:0]       value;
    bit signed [31:0]       step;
    bit [31:0]              avg;
    bit                     neg;
    bit                     last;
} feature_word_t;

typedef struct {
    bit signed [47:0]       score;
    bit                     sat;
} run_result_t;

class perceptron_scoreboard;
    localparam longint W32_MAX = 64'sd2147483647;
    localparam longint W32_MIN = -64'sd2147483648;
    localparam longint W48_MAX = 64'sd140737488355327;
    localparam longint W48_MIN = -64'sd140737488355328;

    bit signed [31:0] weights [spsu_pkg::FEATURE_COUNT_DEF];
    bit signed [47:0] totals [spsu_pkg::FEATURE_COUNT_DEF];
    longint           dot_sum;
    bit               sat_flag;
    run_result_t      expected_runs [$];
    int               errors;
    int               results_seen;
    int               saturated_runs;

    function new();
        foreach (weights[i]) begin
            weights[i] = '0;
            totals[i]  = '0;
        end
        dot_sum        = 0;
        sat_flag       = 1'b0;
        errors         = 0;
        results_seen   = 0;
        saturated_runs = 0;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        if (x > hi)
        begin
            sat_flag = 1'b1;
            return hi;
        end
        if (x < lo)
        begin
            sat_flag = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function void note_word(feature_word_t wd);
        longint      v;
        longint      a;
        longint      u;
        longint      d;
        run_result_t r;
        v = longint'(wd.value);
        a = longint'(wd.step);
        u = longint'({32'd0, wd.avg});
        if (!wd.op)
        begin
            d = (longint'(weights[wd.idx]) * v) >>> 16;
            dot_sum = clamp(dot_sum + d, W48_MIN, W48_MAX);
        end
        else
        begin
            d = clamp((a * v) >>> 16, W32_MIN, W32_MAX);
            if (wd.neg)
                d = clamp(-d, W32_MIN, W32_MAX);
            if (int'(wd.idx) < spsu_pkg::FEATURE_COUNT_DEF)
            begin
                weights[wd.idx] = 32'(clamp(longint'(weights[wd.idx]) + d,
                                            W32_MIN, W32_MAX));
                totals[wd.idx]  = 48'(clamp(longint'(totals[wd.idx]) + ((u * d) >>> 16),
                                            W48_MIN, W48_MAX));
            end
        end
        if (wd.last)
        begin
            r.score = wd.op ? 48'sd0 : dot_sum[47:0];
            r.sat   = sat_flag;
            expected_runs.insert(expected_runs.size(), r);
            dot_sum  = 0;
            sat_flag = 1'b0;
        end
    endfunction

    function void check_result(logic signed [47:0] score, logic saturated);
        run_result_t r;
        results_seen++;
        if (saturated === 1'b1)
            saturated_runs++;
        if (expected_runs.size() == 0)
        begin
            $display("%0t: unexpected result, actual score %0d saturated %b",
                     $time, score, saturated);
            errors++;
            return;
        end
        r = expected_runs.pop_front();
        if (score !== r.score)
        begin
            $display("%0t: score expected %0d actual %0d", $time, r.score, score);
            errors++;
        end
        if (saturated !== r.sat)
        begin
            $display("%0t: saturated expected %b actual %b", $time, r.sat, saturated);
            errors++;
        end
    endfunction

    function int pending();
        return expected_runs.size();
    endfunction

    function void flush();
        run_result_t r;
        while (expected_runs.size() != 0)
        begin
            r = expected_runs.pop_front();
            $display("%0t: missing result, expected score %0d saturated %b",
                     $time, r.score, r.sat);
            errors++;
        end
    endfunction
endclass

module sparse_perceptron_score_update_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [11:0]         feature_index;
    logic signed [31:0]  feature_value;
    logic signed [31:0]  step_size;
    logic [31:0]         average_weight;
    logic                negate;
    logic                last_feature;
    logic                out_valid;
    logic                out_stall;
    logic signed [47:0]  score;
    logic                saturated;

    perceptron_scoreboard sb;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   rx_hold;
    int                   words_sent;
    bit [11:0]            hot_idx [16];

    sparse_perceptron_score_update dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .feature_index  (feature_index),
        .feature_value  (feature_value),
        .step_size      (step_size),
        .average_weight (average_weight),
        .negate         (negate),
        .last_feature   (last_feature),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .score          (score),
        .saturated      (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("sparse_perceptron_score_update: mismatch");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall = 1'b1;
                rx_hold--;
            end
            else
                out_stall = ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(score, saturated);
    end

    function automatic feature_word_t mk(bit o, bit [11:0] i, bit [31:0] v, bit [31:0] s,
                                         bit [31:0] u, bit n, bit l);
        feature_word_t wd;
        wd.op    = o;
        wd.idx   = i;
        wd.value = v;
        wd.step  = s;
        wd.avg   = u;
        wd.neg   = n;
        wd.last  = l;
        return wd;
    endfunction

    function automatic bit [31:0] pick_q16(int small_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < small_pct)
            return $urandom_range(0, 262143) - 131072;
        if (r < small_pct + 12)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'h0001_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic feature_word_t random_word(bit o, bit l);
        bit [11:0] i;
        bit [31:0] u;
        i = ($urandom_range(0, 99) < 70) ? hot_idx[$urandom_range(0, 15)] : 12'($urandom);
        case ($urandom_range(0, 5))
            0, 1: u = 32'h0001_0000;
            2:    u = 32'h0000_0000;
            3:    u = 32'hFFFF_FFFF;
            default: u = $urandom;
        endcase
        return mk(o, i, pick_q16(65), pick_q16(75), u, 1'($urandom_range(0, 1)), l);
    endfunction

    task automatic offer_word(input feature_word_t wd);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        op             = wd.op;
        feature_index  = wd.idx;
        feature_value  = wd.value;
        step_size      = wd.step;
        average_weight = wd.avg;
        negate         = wd.neg;
        last_feature   = wd.last;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(wd);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int  n;
        int  len;
        int  kind;
        bit  o;
        bit  l;
        n = 0;
        while (n < count)
        begin
            len  = $urandom_range(1, 6);
            kind = $urandom_range(0, 99);
            for (int k = 0; k < len; k++)
            begin
                o = (kind < 45) ? 1'b0 : (kind < 80) ? 1'b1 : 1'($urandom_range(0, 1));
                l = (k == len - 1);
                if ($urandom_range(0, 99) < 5)
                    l = ~l;
                offer_word(random_word(o, l));
                n++;
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = 1'b0;
        feature_index  = '0;
        feature_value  = '0;
        step_size      = '0;
        average_weight = '0;
        negate         = 1'b0;
        last_feature   = 1'b0;
        rx_hold        = 0;
        words_sent     = 0;
        tx_idle_pct    = 26;
        rx_idle_pct    = 87;
        hot_idx[0]     = 12'd0;
        hot_idx[1]     = 12'd4095;
        for (int i = 2; i < 16; i++)
            hot_idx[i] = 12'($urandom);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: empty table, weight and delta clamps, sum clamps, rounding.
        offer_word(mk(1'b0, 12'd0,    32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b1, 12'd0,    32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
        offer_word(mk(1'b1, 12'd0,    32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
        offer_word(mk(1'b1, 12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b1, 1'b1));
        offer_word(mk(1'b1, 12'd4094, 32'h0001_0000, 32'h8000_0000, 32'h0002_0000, 1'b1, 1'b1));
        offer_word(mk(1'b0, 12'd0,    32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd0,    32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd0,    32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b0, 12'd0,    32'h8000_0000, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd0,    32'h8000_0000, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd0,    32'h8000_0000, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b1, 12'd1,    32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd1,    32'h0001_0000, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b0, 12'd1,    32'h0000_0001, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b0, 12'd0,    32'h0001_0000, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b1, 12'd2,    32'h0003_8000, 32'h0000_4000, 32'h0,         1'b1, 1'b1));
        offer_word(mk(1'b1, 12'd2,    32'hFFFF_0000, 32'h0002_0000, 32'h8000_0000, 1'b0, 1'b1));
        offer_word(mk(1'b0, 12'd2,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        offer_word(mk(1'b0, 12'd4095, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd4095, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b0));
        offer_word(mk(1'b0, 12'd4095, 32'h7FFF_FFFF, 32'h0,         32'h0,         1'b0, 1'b1));
        offer_word(mk(1'b0, 12'd4094, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1));

        run_random(200);
        drain();
        tx_idle_pct = 87;
        rx_idle_pct = 26;
        run_random(200);
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // The receiver holds off while single-word runs keep coming, so the block backs up.
        rx_hold = 400;
        for (int i = 0; i < 60; i++)
            offer_word(random_word(1'b0, 1'b1));
        drain();
        run_random(170);

        @(negedge clk);
        in_valid = 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        sb.flush();

        $display("Sent %0d feature words through score, update and mixed runs.", words_sent);
        $display("Checked %0d run results, %0d of them with saturation set.",
                 sb.results_seen, sb.saturated_runs);
        if (sb.errors == 0)
            $display("sparse_perceptron_score_update: match");
        else
            $display("sparse_perceptron_score_update: mismatch");
        $finish;
    end

endmodule
